### hdl/h2s_pkg.sv
// shared types, constants and helpers of the 2d histogram inverse-cdf sampler
// no dependencies; used by every module of the block by scoped names
`default_nettype none
package h2s_pkg;

  localparam int MAX_BINS_X  = 64;
  localparam int MAX_BINS_Y  = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int TBL_DEPTH   = MAX_BINS_X * MAX_BINS_Y;
  localparam int TBL_AW      = $clog2(TBL_DEPTH);
  localparam int CNT_W       = TBL_AW + 1;
  localparam int SUM_W       = 28;
  localparam int U_W         = 16;
  localparam int T_W         = SUM_W + U_W;
  localparam int EDGE_W      = 32;
  localparam int EIDX_W      = 7;
  localparam int REG_W       = 7;
  localparam int STEP_W      = $clog2(T_W + 1);
  localparam int IDX_STEPS   = TBL_AW;
  localparam int FRAC_STEPS  = T_W;
  localparam logic [SUM_W-1:0] TOTAL_MAX = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_APPEND = 3'd1,
    FUNC_EDGE_X = 3'd2,
    FUNC_EDGE_Y = 3'd3,
    FUNC_SAMPLE = 3'd4
  } func_t;

  localparam logic REG_BINS_X = 1'b0;
  localparam logic REG_BINS_Y = 1'b1;

  typedef enum logic [1:0] {
    RD_TOTAL = 2'd0,
    RD_MID   = 2'd1,
    RD_CUR   = 2'd2,
    RD_BASE  = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    start_n;
    logic    chk_tot;
    rd_sel_t rd_sel;
    logic    mid_load;
    logic    srch_step;
    logic    i_load;
    logic    cur_load;
    logic    base_load;
    logic    div_idx_start;
    logic    idx_load;
    logic    edge_hi;
    logic    e0_load;
    logic    e1_load;
    logic    fdiv_start;
    logic    frac_load;
    logic    mul;
    logic    sum;
    logic    load_out;
    logic    load_empty;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic n_zero;
    logic tot_zero;
    logic lo_lt_hi;
    logic div_busy;
    logic do_div;
    logic out_free;
  } status_t;

  // register value 0 counts as 1, above the maximum counts as the maximum
  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v,
                                                 input logic [REG_W-1:0] hi);
    logic [REG_W-1:0] r;
    r = v;
    if (v == '0) r = REG_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/h2s_div.sv
// restoring serial divider, one quotient bit a cycle, step count set at start
// depends on h2s_pkg
`default_nettype none
module h2s_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [h2s_pkg::STEP_W-1:0]  steps,
  input  wire logic [h2s_pkg::T_W-1:0]     num,
  input  wire logic [h2s_pkg::SUM_W-1:0]   den,
  output logic                             busy,
  output logic [h2s_pkg::T_W-1:0]          quo,
  output logic [h2s_pkg::SUM_W-1:0]        rem
);

  logic [h2s_pkg::STEP_W-1:0] cnt;
  logic [h2s_pkg::T_W-1:0]    num_sh;
  logic [h2s_pkg::SUM_W-1:0]  den_r;
  logic [h2s_pkg::SUM_W:0]    rem_sh;

  assign busy   = (cnt != '0);
  assign rem_sh = {rem, num_sh[h2s_pkg::T_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - h2s_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[h2s_pkg::T_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_r}) begin
        rem <= h2s_pkg::SUM_W'(rem_sh - {1'b0, den_r});
        quo <= {quo[h2s_pkg::T_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[h2s_pkg::SUM_W-1:0];
        quo <= {quo[h2s_pkg::T_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### hdl/h2s_ctrl.sv
// sequencer of the sampler: loads are applied from the idle state, a sample walks the states
// depends on h2s_pkg
`default_nettype none
module h2s_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire h2s_pkg::status_t  status,
  output h2s_pkg::cmd_t          cmd
);

  typedef enum logic [18:0] {
    S_IDLE    = 19'b0000000000000000001,
    S_START   = 19'b0000000000000000010,
    S_TOT_RD  = 19'b0000000000000000100,
    S_TOT_CHK = 19'b0000000000000001000,
    S_SRCH_RD = 19'b0000000000000010000,
    S_SRCH_CP = 19'b0000000000000100000,
    S_CUR_RD  = 19'b0000000000001000000,
    S_BASE_RD = 19'b0000000000010000000,
    S_DIVI_ST = 19'b0000000000100000000,
    S_DIVI    = 19'b0000000001000000000,
    S_EDGE0   = 19'b0000000010000000000,
    S_EDGE1   = 19'b0000000100000000000,
    S_EDGE2   = 19'b0000001000000000000,
    S_FDIV_ST = 19'b0000010000000000000,
    S_FDIV    = 19'b0000100000000000000,
    S_MUL     = 19'b0001000000000000000,
    S_SUM     = 19'b0010000000000000000,
    S_OUT     = 19'b0100000000000000000,
    S_EMPTY   = 19'b1000000000000000000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = h2s_pkg::RD_TOTAL;
    unique case (state)
      S_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid && status.is_sample) state_next = S_START;
      end
      S_START: begin
        cmd.start_n = 1'b1;
        state_next  = S_TOT_RD;
      end
      S_TOT_RD: begin
        cmd.rd_sel = h2s_pkg::RD_TOTAL;
        state_next = status.n_zero ? S_EMPTY : S_TOT_CHK;
      end
      S_TOT_CHK: begin
        cmd.chk_tot = 1'b1;
        state_next  = status.tot_zero ? S_EMPTY : S_SRCH_RD;
      end
      S_SRCH_RD: begin
        cmd.rd_sel   = h2s_pkg::RD_MID;
        cmd.mid_load = 1'b1;
        state_next   = status.lo_lt_hi ? S_SRCH_CP : S_CUR_RD;
      end
      S_SRCH_CP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_SRCH_RD;
      end
      S_CUR_RD: begin
        cmd.rd_sel = h2s_pkg::RD_CUR;
        cmd.i_load = 1'b1;
        state_next = S_BASE_RD;
      end
      S_BASE_RD: begin
        cmd.rd_sel   = h2s_pkg::RD_BASE;
        cmd.cur_load = 1'b1;
        state_next   = S_DIVI_ST;
      end
      S_DIVI_ST: begin
        cmd.base_load     = 1'b1;
        cmd.div_idx_start = 1'b1;
        state_next        = S_DIVI;
      end
      S_DIVI: begin
        if (!status.div_busy) begin
          cmd.idx_load = 1'b1;
          state_next   = S_EDGE0;
        end
      end
      S_EDGE0: begin
        state_next = S_EDGE1;
      end
      S_EDGE1: begin
        cmd.e0_load = 1'b1;
        cmd.edge_hi = 1'b1;
        state_next  = S_EDGE2;
      end
      S_EDGE2: begin
        cmd.e1_load = 1'b1;
        state_next  = S_FDIV_ST;
      end
      S_FDIV_ST: begin
        cmd.fdiv_start = status.do_div;
        state_next     = status.do_div ? S_FDIV : S_MUL;
      end
      S_FDIV: begin
        if (!status.div_busy) begin
          cmd.frac_load = 1'b1;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (status.out_free) begin
          cmd.load_empty = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/h2s_dp.sv
// datapath: cumulative table, edge memories, search, divider, interpolation
// depends on h2s_pkg and h2s_div
`default_nettype none
module h2s_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [h2s_pkg::REG_W-1:0]   cfg_data,
  input  wire logic [87:0]                 s_tdata,
  input  wire logic [2:0]                  s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [63:0]                      m_tdata,
  output logic                             m_tuser,
  input  wire h2s_pkg::cmd_t               cmd,
  output h2s_pkg::status_t                 status
);

  localparam int AW  = h2s_pkg::TBL_AW;
  localparam int CW  = h2s_pkg::CNT_W;
  localparam int SW  = h2s_pkg::SUM_W;
  localparam int TW  = h2s_pkg::T_W;
  localparam int EW  = h2s_pkg::EDGE_W;
  localparam int XW  = h2s_pkg::EIDX_W;
  localparam int RW  = h2s_pkg::REG_W;
  localparam int UW  = h2s_pkg::U_W;

  // input fields
  logic [XW-1:0]                    in_eidx;
  logic signed [h2s_pkg::WEIGHT_BITS-1:0] in_w;
  logic [EW-1:0]                    in_ev;
  logic [UW-1:0]                    in_ua, in_ub;
  assign in_eidx = s_tdata[6:0];
  assign in_w    = s_tdata[22:7];
  assign in_ev   = s_tdata[54:23];
  assign in_ua   = s_tdata[70:55];
  assign in_ub   = s_tdata[86:71];

  logic [RW-1:0] bins_x, bins_y, bxn, byn;
  logic [CW-1:0] loaded, n_r;
  logic [SW-1:0] total;
  logic [UW-1:0] ua_r, ub_r;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_x <= RW'(1);
      bins_y <= RW'(1);
    end else if (cfg_we) begin
      if (cfg_index == h2s_pkg::REG_BINS_X) bins_x <= cfg_data;
      else                                  bins_y <= cfg_data;
    end
  end

  assign bxn = h2s_pkg::clamp_reg(bins_x, RW'(h2s_pkg::MAX_BINS_X));
  assign byn = h2s_pkg::clamp_reg(bins_y, RW'(h2s_pkg::MAX_BINS_Y));

  // load path
  logic [SW-1:0] w_pos;
  logic [SW:0]   sum_w;
  logic [SW-1:0] sum_sat;
  logic          do_clear, do_append, do_ex, do_ey;
  assign w_pos     = in_w[h2s_pkg::WEIGHT_BITS-1] ? '0 : SW'(in_w);
  assign sum_w     = {1'b0, total} + {1'b0, w_pos};
  assign sum_sat   = sum_w[SW] ? h2s_pkg::TOTAL_MAX : sum_w[SW-1:0];
  assign do_clear  = cmd.accept && (s_tuser == h2s_pkg::FUNC_CLEAR);
  assign do_append = cmd.accept && (s_tuser == h2s_pkg::FUNC_APPEND) && !loaded[CW-1];
  assign do_ex     = cmd.accept && (s_tuser == h2s_pkg::FUNC_EDGE_X)
                     && (in_eidx <= XW'(h2s_pkg::MAX_BINS_X));
  assign do_ey     = cmd.accept && (s_tuser == h2s_pkg::FUNC_EDGE_Y)
                     && (in_eidx <= XW'(h2s_pkg::MAX_BINS_Y));

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      total  <= '0;
    end else if (do_clear) begin
      loaded <= '0;
      total  <= '0;
    end else if (do_append) begin
      loaded <= loaded + CW'(1);
      total  <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ua_r <= in_ua;
      ub_r <= in_ub;
    end
  end

  // search registers
  logic [CW-1:0]  lo, hi, mid_r, i_c;
  logic [CW:0]    lo_hi;
  logic [CW-1:0]  mid_c;
  logic [AW-1:0]  i_r;
  logic [TW-1:0]  t_r;
  logic [SW-1:0]  cur_r, base_r, d_c;
  logic [TW-1:0]  base_sh;

  assign lo_hi = {1'b0, lo} + {1'b0, hi};
  assign mid_c = lo_hi[CW:1];
  assign i_c   = (lo >= n_r) ? (n_r - CW'(1)) : lo;

  // cumulative table, one write and one registered read port
  logic [SW-1:0] tbl [0:h2s_pkg::TBL_DEPTH-1];
  logic [SW-1:0] tbl_rd;
  logic [AW-1:0] tbl_ra;

  always_comb begin
    case (cmd.rd_sel)
      h2s_pkg::RD_TOTAL: tbl_ra = AW'(n_r - CW'(1));
      h2s_pkg::RD_MID:   tbl_ra = mid_c[AW-1:0];
      h2s_pkg::RD_CUR:   tbl_ra = i_c[AW-1:0];
      default:           tbl_ra = i_r - AW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_append) tbl[loaded[AW-1:0]] <= sum_sat;
    tbl_rd <= tbl[tbl_ra];
  end

  function automatic logic [TW-1:0] in_ua_mul(input logic [UW-1:0] a,
                                              input logic [SW-1:0] b);
    return TW'(a) * TW'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.start_n) begin
      n_r <= (CW'(bxn) * CW'(byn) > loaded) ? loaded : CW'(CW'(bxn) * CW'(byn));
    end
    if (cmd.chk_tot) begin
      t_r <= TW'(in_ua_mul(ua_r, tbl_rd));
      lo  <= '0;
      hi  <= n_r;
    end
    if (cmd.mid_load) mid_r <= mid_c;
    if (cmd.srch_step) begin
      if ({tbl_rd, {UW{1'b0}}} > t_r) hi <= mid_r;
      else                            lo <= mid_r + CW'(1);
    end
    if (cmd.i_load)    i_r    <= i_c[AW-1:0];
    if (cmd.cur_load)  cur_r  <= tbl_rd;
    if (cmd.base_load) base_r <= (i_r == '0) ? '0 : tbl_rd;
  end

  assign base_sh = {base_r, {UW{1'b0}}};
  assign d_c     = cur_r - base_r;

  // shared divider: bin index by bins_x, then interpolation fraction
  logic                     div_start, div_busy;
  logic [h2s_pkg::STEP_W-1:0] div_steps;
  logic [TW-1:0]            div_num, div_quo;
  logic [SW-1:0]            div_den, div_rem;

  assign div_start = cmd.div_idx_start || cmd.fdiv_start;
  assign div_steps = cmd.fdiv_start ? h2s_pkg::STEP_W'(h2s_pkg::FRAC_STEPS)
                                    : h2s_pkg::STEP_W'(h2s_pkg::IDX_STEPS);
  assign div_num   = cmd.fdiv_start ? (t_r - base_sh) : {i_r, {(TW-AW){1'b0}}};
  assign div_den   = cmd.fdiv_start ? d_c : SW'(bxn);

  h2s_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .steps (div_steps),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // edge memories
  logic [EW-1:0] xe [0:h2s_pkg::MAX_BINS_X];
  logic [EW-1:0] ye [0:h2s_pkg::MAX_BINS_Y];
  logic [EW-1:0] xe_rd, ye_rd, xe0, xe1, ye0, ye1;
  logic [XW-1:0] bx_r, by_r, xa, ya;

  assign xa = cmd.edge_hi ? (bx_r + XW'(1)) : bx_r;
  assign ya = cmd.edge_hi ? (by_r + XW'(1)) : by_r;

  always_ff @(posedge clk) begin
    if (do_ex) xe[in_eidx] <= in_ev;
    if (do_ey) ye[in_eidx] <= in_ev;
    xe_rd <= xe[xa];
    ye_rd <= ye[ya];
  end

  logic [UW-1:0]      frac_r;
  logic [EW:0]        wx, wy;
  logic signed [49:0] px, py;
  logic [EW-1:0]      x_r, y_r;

  assign wx = {xe1[EW-1], xe1} - {xe0[EW-1], xe0};
  assign wy = {ye1[EW-1], ye1} - {ye0[EW-1], ye0};

  always_ff @(posedge clk) begin
    if (cmd.idx_load) begin
      bx_r <= XW'(div_rem);
      by_r <= XW'(div_quo);
    end
    if (cmd.e0_load) begin
      xe0 <= xe_rd;
      ye0 <= ye_rd;
    end
    if (cmd.e1_load) begin
      xe1 <= xe_rd;
      ye1 <= ye_rd;
    end
    if (cmd.frac_load) begin
      frac_r <= (div_quo[TW-1:UW] != '0) ? {UW{1'b1}} : div_quo[UW-1:0];
    end
    if (cmd.mul) begin
      px <= $signed(wx) * $signed({1'b0, frac_r});
      py <= $signed(wy) * $signed({1'b0, ub_r});
    end
    if (cmd.sum) begin
      x_r <= status.do_div ? (xe0 + px[47:16]) : (xe0 + wx[EW:1]);
      y_r <= ye0 + py[47:16];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out || cmd.load_empty) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {y_r, x_r};
      m_tuser <= 1'b0;
    end else if (cmd.load_empty) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
    end
  end

  assign status.is_sample = (s_tuser == h2s_pkg::FUNC_SAMPLE);
  assign status.n_zero    = (n_r == '0);
  assign status.tot_zero  = (tbl_rd == '0);
  assign status.lo_lt_hi  = (lo < hi);
  assign status.div_busy  = div_busy;
  assign status.do_div    = (d_c != '0) && (t_r >= base_sh);
  assign status.out_free  = !m_tvalid || m_tready;

endmodule
`default_nettype wire

### hdl/histogram_2d_inverse_cdf_sampler.sv
// sequence: load transfers are applied while idle; a sample reads the total, runs k search
// probes (at most floor(log2(n)) + 1), the bin split divide and the edge reads, then the
// fraction divide when it runs and the interpolation; an empty histogram skips to its result
// throughput: one sample in flight, the next transfer in the cycle after its result loads
// reset: synchronous active-high rst clears fill count, total, bins_x/bins_y to 1
// and the output valid; table and edge memories keep their contents
// top level, depends on h2s_pkg, h2s_ctrl, h2s_dp
`default_nettype none
module histogram_2d_inverse_cdf_sampler (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes: index 0 bins_x, index 1 bins_y
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // edge_index[6:0], bin_weight[22:7], edge_value[54:23],
  // uniform_a[70:55], uniform_b[86:71], pad[87]
  input  wire logic [87:0] s_tdata,
  // func[2:0]
  input  wire logic [2:0]  s_tuser,
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // sample_x[31:0], sample_y[63:32]
  output logic [63:0]      m_tdata,
  // status[0]
  output logic             m_tuser
);

  h2s_pkg::cmd_t    cmd;
  h2s_pkg::status_t status;

  // sequencer: accepts only while idle, walks one sample through
  h2s_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath with memories, divider and output register
  h2s_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

### hdl/h2s_chk.sv
// port-level checker of the sampler and its bind to the top level
// depends on h2s_pkg and histogram_2d_inverse_cdf_sampler
`default_nettype none
module h2s_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [2:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 64'd0) else $error("empty result not zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result valid after reset");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == h2s_pkg::FUNC_SAMPLE) |=> !s_tready)
    else $error("sample transfer did not occupy the block");

endmodule

bind histogram_2d_inverse_cdf_sampler h2s_chk u_h2s_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

### tb/testbench.sv
// self-checking testbench for histogram_2d_inverse_cdf_sampler
// loads random histograms and edges, draws samples and checks every result
// depends on h2s_pkg and the block's rtl
`timescale 1ns / 100ps
module testbench;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        empty;
  } sample_t;

  // keeps a copy of the histogram state and the samples still owed by the block
  class sample_scoreboard;
    logic [27:0] cum [h2s_pkg::TBL_DEPTH];
    logic signed [31:0] xe [h2s_pkg::MAX_BINS_X+1];
    logic signed [31:0] ye [h2s_pkg::MAX_BINS_Y+1];
    int unsigned loaded;
    logic [27:0] total;
    int unsigned nbx, nby;
    sample_t owed[$];
    int mismatches;
    int checked;

    function void reset_state();
      loaded = 0; total = 0; nbx = 1; nby = 1;
      mismatches = 0; checked = 0;
      foreach (xe[k]) xe[k] = 0;
      foreach (ye[k]) ye[k] = 0;
    endfunction

    function void set_reg(logic idx, logic [6:0] v);
      int unsigned c;
      c = (v == 0) ? 1 : v;
      if (idx == h2s_pkg::REG_BINS_X)
        nbx = (c > h2s_pkg::MAX_BINS_X) ? h2s_pkg::MAX_BINS_X : c;
      else nby = (c > h2s_pkg::MAX_BINS_Y) ? h2s_pkg::MAX_BINS_Y : c;
    endfunction

    function sample_t draw(logic [15:0] ua, logic [15:0] ub);
      sample_t r;
      int unsigned n, lo, hi, mid, i, bx, by;
      logic [43:0] t, base, d, frac;
      logic signed [63:0] w, x, y;
      n = nbx * nby;
      if (n > loaded) n = loaded;
      r.sx = 0; r.sy = 0; r.empty = 1;
      if (n == 0 || cum[n-1] == 0) return r;
      t = 44'(ua) * 44'(cum[n-1]);
      lo = 0; hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if ({cum[mid], 16'h0} > t) hi = mid;
        else lo = mid + 1;
      end
      i = (lo >= n) ? n - 1 : lo;
      bx = i % nbx;
      by = i / nbx;
      base = (i > 0) ? 44'(cum[i-1]) : 44'd0;
      d = 44'(cum[i]) - base;
      w = 64'(xe[bx+1]) - 64'(xe[bx]);
      if (d > 0 && t >= (base << 16)) begin
        frac = (t - (base << 16)) / d;
        if (frac > 44'hFFFF) frac = 44'hFFFF;
        x = 64'(xe[bx]) + ((w * $signed({20'd0, frac})) >>> 16);
      end else begin
        x = 64'(xe[bx]) + (w >>> 1);
      end
      w = 64'(ye[by+1]) - 64'(ye[by]);
      y = 64'(ye[by]) + ((w * $signed({48'd0, ub})) >>> 16);
      r.sx = x[31:0]; r.sy = y[31:0]; r.empty = 0;
      return r;
    endfunction

    // note an accepted input transfer
    function void note_input(logic [2:0] fn, logic [87:0] d);
      logic signed [15:0] wt;
      logic [28:0] s;
      case (fn)
        h2s_pkg::FUNC_CLEAR: begin
          loaded = 0; total = 0;
        end
        h2s_pkg::FUNC_APPEND: begin
          wt = d[22:7];
          if (loaded < h2s_pkg::TBL_DEPTH) begin
            s = 29'(total) + ((wt < 0) ? 29'd0 : 29'(wt));
            total = (s > 29'(h2s_pkg::TOTAL_MAX)) ? h2s_pkg::TOTAL_MAX : s[27:0];
            cum[loaded] = total;
            loaded++;
          end
        end
        h2s_pkg::FUNC_EDGE_X: if (d[6:0] <= h2s_pkg::MAX_BINS_X) xe[d[6:0]] = d[54:23];
        h2s_pkg::FUNC_EDGE_Y: if (d[6:0] <= h2s_pkg::MAX_BINS_Y) ye[d[6:0]] = d[54:23];
        h2s_pkg::FUNC_SAMPLE: owed.push_back(draw(d[70:55], d[86:71]));
        default: ;
      endcase
    endfunction

    // check one accepted result transfer against the oldest owed sample
    function void check_result(logic [63:0] d, logic u);
      sample_t e;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%h y=%h st=%b", d[31:0], d[63:32], u);
        return;
      end
      e = owed.pop_front();
      if (e.sx !== d[31:0] || e.sy !== d[63:32] || e.empty !== u) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample %0d: expected x=%h y=%h st=%b, got x=%h y=%h st=%b", checked,
                   e.sx, e.sy, e.empty, d[31:0], d[63:32], u);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0, cfg_index = 0;
  logic [6:0] cfg_data = 0;
  logic s_tvalid = 0, m_tready = 0;
  logic [87:0] s_tdata = 0;
  logic [2:0] s_tuser = 0;
  logic s_tready, m_tvalid, m_tuser;
  logic [63:0] m_tdata;

  sample_scoreboard sb;
  int cycles = 0;
  bit quiet_tail = 0;
  int samples_sent = 0, loads_sent = 0;
  localparam int CYCLE_LIMIT = 2000000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  histogram_2d_inverse_cdf_sampler dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  // result side: check transfers, stall in random bursts except in the tail
  int stall_left = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic send(logic [2:0] fn, logic [87:0] d);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= fn;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(fn, d);
    if (fn == h2s_pkg::FUNC_SAMPLE) samples_sent++;
    else loads_sent++;
  endtask

  // end the item stream and hold off until every owed sample has arrived
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  function automatic logic [87:0] pack(logic [6:0] ei, logic [15:0] wt, logic [31:0] ev,
                                       logic [15:0] ua, logic [15:0] ub);
    return {1'b0, ub, ua, ev, wt, ei};
  endfunction

  task automatic weight(logic [15:0] wt);
    send(h2s_pkg::FUNC_APPEND, pack(7'($urandom), wt, $urandom, 16'($urandom),
                                    16'($urandom)));
  endtask

  task automatic sample(logic [15:0] ua, logic [15:0] ub);
    send(h2s_pkg::FUNC_SAMPLE, pack(7'($urandom), 16'($urandom), $urandom, ua, ub));
  endtask

  // increasing edges, or fully random values to reach wrap and negative widths
  task automatic load_edges(bit wild);
    logic [31:0] v;
    v = $urandom;
    for (int k = 0; k <= h2s_pkg::MAX_BINS_X; k++) begin
      v = wild ? $urandom : v + $urandom_range(0, 32'h00200000);
      send(h2s_pkg::FUNC_EDGE_X, pack(7'(k), 16'($urandom), v, 16'($urandom),
                                      16'($urandom)));
    end
    v = $urandom;
    for (int k = 0; k <= h2s_pkg::MAX_BINS_Y; k++) begin
      v = wild ? $urandom : v + $urandom_range(0, 32'h00200000);
      send(h2s_pkg::FUNC_EDGE_Y, pack(7'(k), 16'($urandom), v, 16'($urandom),
                                      16'($urandom)));
    end
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'h0;
      1: return 16'h7FFF;
      2: return 16'h8000 | 16'($urandom);
      3: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_uniform();
    case ($urandom_range(0, 5))
      0: return 16'h0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  int bxs, bys, nfill;

  initial begin
    sb = new();
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty histogram at reset settings, then edge extremes
    sample(16'h0, 16'hFFFF);
    load_edges(0);
    send(h2s_pkg::FUNC_EDGE_X, pack(7'd65, 16'h0, 32'h80000000, 16'h0, 16'h0));
    send(h2s_pkg::FUNC_EDGE_Y, pack(7'd127, 16'h0, 32'h7FFFFFFF, 16'h0, 16'h0));
    send(3'd5, pack(7'd0, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
    send(3'd7, '0);
    weight(16'h0);
    sample(16'h1234, 16'h0);  // loaded but zero total
    weight(16'h8000);         // negative, clamped
    weight(16'h7FFF);
    weight(16'h0);            // zero-width bin in the middle
    weight(16'h0001);
    drain();
    write_reg(h2s_pkg::REG_BINS_X, 7'd0);   // counts as one
    write_reg(h2s_pkg::REG_BINS_Y, 7'd127); // clamps to the maximum
    sample(16'h0, 16'h0);
    sample(16'hFFFF, 16'hFFFF);
    sample(16'h8000, 16'h8000);
    send(h2s_pkg::FUNC_CLEAR, '0);
    sample(16'h4000, 16'h4000);    // cleared: empty again
    drain();

    // random phases: new shape, edges, weights, then mostly samples
    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 6) quiet_tail = 1;
      case (ph % 4)
        0: begin bxs = 1; bys = 1; end
        1: begin bxs = 64; bys = 64; end
        default: begin bxs = $urandom_range(0, 9); bys = $urandom_range(0, 9); end
      endcase
      write_reg(h2s_pkg::REG_BINS_X, 7'(bxs));
      write_reg(h2s_pkg::REG_BINS_Y, 7'(bys));
      send(h2s_pkg::FUNC_CLEAR, '0);
      if (ph % 5 != 3) load_edges(ph % 7 == 2);
      nfill = (ph % 4 == 1) ? $urandom_range(2, 12)
              : sb.nbx * sb.nby + $urandom_range(0, 3) - 1;
      for (int k = 0; k < nfill; k++) begin
        if (ph == 5 && k > 0) weight(16'h7FFF);   // run of the largest weights
        else weight(rand_weight());
      end
      for (int k = 0; k < 90; k++) begin
        if ($urandom_range(0, 19) == 0) send(3'($urandom_range(0, 7)) | 3'd4 & 3'd5,
                                             pack(7'($urandom), 16'($urandom), $urandom,
                                                  16'($urandom), 16'($urandom)));
        else sample(rand_uniform(), rand_uniform());
      end
      drain();
    end

    $display("covered %0d samples and %0d load transfers over 8 histogram shapes",
             samples_sent, loads_sent);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d samples never arrived", sb.mismatches, sb.owed.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### sim.f
hdl/h2s_pkg.sv
hdl/h2s_div.sv
hdl/h2s_ctrl.sv
hdl/h2s_dp.sv
hdl/histogram_2d_inverse_cdf_sampler.sv
hdl/h2s_chk.sv
tb/testbench.sv
